[hdl/lamp_power_mode_controller_top_macros.svh]
// Assertion macros for the lamp power-mode controller checker.
// Used by lpmc_checker; needs i_clk and i_rst_n in the using scope.
`ifndef LAMP_POWER_MODE_CONTROLLER_TOP_MACROS_SVH
`define LAMP_POWER_MODE_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define LPMC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lpmc check failed");

// next-cycle implication, checked out of reset
`define LPMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lpmc check failed");

`endif

[hdl/lpmc_pkg.sv]
// Types and constants of the lamp power-mode controller.
// No dependencies; imported by every module of the block.
package lpmc_pkg;

    localparam int DIM_W   = 8;
    localparam int SLEEP_W = 24;
    localparam int PAUSE_W = 16;
    localparam int CFG_W   = 24;

    localparam int BEACON_PERIOD_DEF = 500;

    localparam logic [PAUSE_W-1:0] PAUSE_RELOAD_RST = 16'd400;
    localparam logic [SLEEP_W-1:0] SLEEP_TOTAL_RST  = 24'h100000;
    localparam logic [DIM_W-1:0]   DIM_RST          = 8'd255;

    typedef enum logic [2:0] {
        MODE_RUN           = 3'd0,
        MODE_PAUSE         = 3'd1,
        MODE_ENTER_STANDBY = 3'd2,
        MODE_STANDBY       = 3'd3,
        MODE_LEAVE_STANDBY = 3'd4,
        MODE_ENTER_SLEEP   = 3'd5,
        MODE_SLEEP         = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_ACTIVITY   = 3'd1,
        OP_MODE_REQ   = 3'd2,
        OP_SET_SERVER = 3'd3,
        OP_SETUP_OK   = 3'd4,
        OP_SET_DIM    = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        LINK_SEARCH   = 2'd0,
        LINK_IDENTIFY = 2'd1,
        LINK_READY    = 2'd2
    } t_link;

    typedef enum logic {
        CFG_PAUSE_RELOAD = 1'b0,
        CFG_SLEEP_TOTAL  = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_DIVIDE = 1'b1
    } t_state;

    typedef struct packed {
        logic       busy;
        logic       done;
    } t_div_stat;

    typedef struct packed {
        logic [2:0] operation;
        logic [2:0] requested_mode;
        logic [7:0] server_address;
        logic [7:0] dim_value;
    } t_item;

    typedef struct packed {
        logic [2:0] current_mode;
        logic       running_flag;
        logic [7:0] dim_level_out;
        logic       beacon_fire;
        logic [1:0] beacon_kind;
        logic       beacon_broadcast;
        logic [7:0] beacon_dest;
    } t_result;

endpackage

[hdl/lamp_power_mode_controller_top.sv]
// Lamp power-mode controller: modes, sleep fade, pause countdown, beacon timer.
// Depends on lpmc_pkg and lpmc_div.
//
// Input channel i_in_valid/o_in_ready carries one beat per operation (tick,
// activity, mode request, set server, setup ok, set dim). Every beat yields
// exactly one result beat on o_out_valid/i_out_ready, registered: the result
// is shown the cycle after the input beat is taken.
// Throughput: one beat per cycle for every operation, except a tick that
// enters sleep at a nonzero dim level. That tick starts the serial divider
// (one quotient bit per cycle over the 24-bit sleep total), and the input
// stays not ready until the sleep step is stored.
// The output register holds one result; while it is full and the receiver
// stalls, o_in_ready is low, so no result is dropped.
// Configuration: i_cfg_we writes pause_reload (index 0) or sleep_total
// (index 1) at once; write only while no result is outstanding.
// Reset (i_rst_n low at a clock edge) restores all mode, dim, timer and
// link state and both registers to their defaults; no result is pending.
module lamp_power_mode_controller_top
    import lpmc_pkg::*;
#(
    parameter int BEACON_PERIOD = BEACON_PERIOD_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_item            i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_result          o_out,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int BEACON_W = $clog2(BEACON_PERIOD + 1);
    localparam logic [BEACON_W-1:0] BEACON_RELOAD = BEACON_W'(BEACON_PERIOD);

    t_state               r_state, n_state;
    t_mode                r_mode, n_mode;
    t_mode                r_saved_mode, n_saved_mode;
    logic [DIM_W-1:0]     r_dim, n_dim;
    logic [DIM_W-1:0]     r_saved_dim, n_saved_dim;
    logic                 r_running, n_running;
    logic [SLEEP_W-1:0]   r_sleep_cnt, n_sleep_cnt;
    logic [SLEEP_W-1:0]   r_sleep_step, n_sleep_step;
    logic [PAUSE_W-1:0]   r_pause_cnt, n_pause_cnt;
    logic [BEACON_W-1:0]  r_beacon_cnt, n_beacon_cnt;
    t_link                r_link, n_link;
    logic [7:0]           r_server, n_server;
    logic [PAUSE_W-1:0]   r_pause_reload;
    logic [SLEEP_W-1:0]   r_sleep_total;
    logic                 r_out_valid, n_out_valid;
    t_result              r_out, n_out;

    logic                 w_in_fire;
    logic                 w_div_start;
    t_div_stat            w_div_stat;
    logic [SLEEP_W-1:0]   w_div_quo;
    logic [SLEEP_W-1:0]   w_cnt_inc;
    logic [DIM_W-1:0]     w_dim_dec;

    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_cnt_inc  = r_sleep_cnt + 1'b1;
    assign w_dim_dec  = r_dim - 1'b1;

    lpmc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sleep_total),
        .i_divisor  (r_dim),
        .o_stat     (w_div_stat),
        .o_quotient (w_div_quo)
    );

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_saved_mode = r_saved_mode;
        n_dim        = r_dim;
        n_saved_dim  = r_saved_dim;
        n_running    = r_running;
        n_sleep_cnt  = r_sleep_cnt;
        n_sleep_step = r_sleep_step;
        n_pause_cnt  = r_pause_cnt;
        n_beacon_cnt = r_beacon_cnt;
        n_link       = r_link;
        n_server     = r_server;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        w_div_start  = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        n_out.beacon_fire      = 1'b0;
        n_out.beacon_kind      = '0;
        n_out.beacon_broadcast = 1'b0;
        n_out.beacon_dest      = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    case (t_op'(i_in.operation))
                        OP_TICK: begin
                            case (r_mode)
                                MODE_RUN: begin
                                    n_running = 1'b1;
                                end
                                MODE_PAUSE: begin
                                    n_running = 1'b0;
                                end
                                MODE_ENTER_STANDBY: begin
                                    n_saved_dim = r_dim;
                                    n_dim       = '0;
                                    n_running   = 1'b0;
                                    n_mode      = MODE_STANDBY;
                                end
                                MODE_LEAVE_STANDBY: begin
                                    n_dim     = r_saved_dim;
                                    n_running = 1'b1;
                                    n_mode    = r_saved_mode;
                                end
                                MODE_ENTER_SLEEP: begin
                                    n_sleep_cnt = '0;
                                    if (r_dim == '0) begin
                                        n_running = 1'b0;
                                        n_mode    = MODE_STANDBY;
                                    end else begin
                                        w_div_start = 1'b1;
                                        n_state     = ST_DIVIDE;
                                        n_saved_dim = r_dim;
                                        n_mode      = MODE_SLEEP;
                                    end
                                end
                                MODE_SLEEP: begin
                                    if (w_cnt_inc == r_sleep_step) begin
                                        n_sleep_cnt = '0;
                                        n_dim       = w_dim_dec;
                                        if (w_dim_dec == '0) begin
                                            n_mode    = MODE_STANDBY;
                                            n_running = 1'b0;
                                        end
                                    end else begin
                                        n_sleep_cnt = w_cnt_inc;
                                    end
                                end
                                default: begin
                                end
                            endcase

                            if (r_beacon_cnt == '0) begin
                                n_beacon_cnt           = BEACON_RELOAD;
                                n_out.beacon_fire      = 1'b1;
                                n_out.beacon_kind      = r_link;
                                n_out.beacon_broadcast = (r_link == LINK_SEARCH);
                                n_out.beacon_dest      = r_server;
                            end else begin
                                n_beacon_cnt = r_beacon_cnt - 1'b1;
                            end

                            if (r_pause_cnt != '0) begin
                                n_pause_cnt = r_pause_cnt - 1'b1;
                                if (r_pause_cnt == PAUSE_W'(1)) begin
                                    n_mode = r_saved_mode;
                                end
                            end
                        end
                        OP_ACTIVITY: begin
                            if (r_pause_cnt != '0) begin
                                n_pause_cnt = r_pause_reload;
                            end
                            if (r_mode != MODE_PAUSE) begin
                                n_saved_mode = r_mode;
                                n_mode       = MODE_PAUSE;
                                n_pause_cnt  = r_pause_reload;
                            end
                        end
                        OP_MODE_REQ: begin
                            if (i_in.requested_mode inside {[MODE_RUN:MODE_SLEEP]}) begin
                                n_mode = t_mode'(i_in.requested_mode);
                            end
                        end
                        OP_SET_SERVER: begin
                            n_server = i_in.server_address;
                            n_link   = LINK_IDENTIFY;
                        end
                        OP_SETUP_OK: begin
                            n_link = LINK_READY;
                        end
                        OP_SET_DIM: begin
                            n_dim = i_in.dim_value;
                        end
                        default: begin
                        end
                    endcase

                    n_out_valid         = 1'b1;
                    n_out.current_mode  = n_mode;
                    n_out.running_flag  = n_running;
                    n_out.dim_level_out = n_dim;
                end else begin
                    n_out = r_out;
                end
            end
            ST_DIVIDE: begin
                n_out = r_out;
                if (w_div_stat.done) begin
                    n_sleep_step = w_div_quo;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_out   = r_out;
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_RUN;
            r_saved_mode   <= MODE_RUN;
            r_dim          <= DIM_RST;
            r_saved_dim    <= '0;
            r_running      <= 1'b1;
            r_sleep_cnt    <= '0;
            r_sleep_step   <= '0;
            r_pause_cnt    <= '0;
            r_beacon_cnt   <= BEACON_RELOAD;
            r_link         <= LINK_SEARCH;
            r_server       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_mode         <= n_mode;
            r_saved_mode   <= n_saved_mode;
            r_dim          <= n_dim;
            r_saved_dim    <= n_saved_dim;
            r_running      <= n_running;
            r_sleep_cnt    <= n_sleep_cnt;
            r_sleep_step   <= n_sleep_step;
            r_pause_cnt    <= n_pause_cnt;
            r_beacon_cnt   <= n_beacon_cnt;
            r_link         <= n_link;
            r_server       <= n_server;
            r_out_valid    <= n_out_valid;
        end
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pause_reload <= PAUSE_RELOAD_RST;
            r_sleep_total  <= SLEEP_TOTAL_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PAUSE_RELOAD: r_pause_reload <= i_cfg_data[PAUSE_W-1:0];
                CFG_SLEEP_TOTAL:  r_sleep_total  <= i_cfg_data[SLEEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[hdl/lpmc_div.sv]
// Serial restoring divider: sleep step = sleep total / dim level.
// One quotient bit per cycle; depends on lpmc_pkg.
module lpmc_div
    import lpmc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SLEEP_W-1:0] i_dividend,
    input  logic [DIM_W-1:0]   i_divisor,
    output t_div_stat          o_stat,
    output logic [SLEEP_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(SLEEP_W);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [SLEEP_W-1:0] r_quo, n_quo;
    logic [DIM_W-1:0]   r_rem, n_rem;
    logic [DIM_W-1:0]   r_den, n_den;
    logic [DIM_W:0]     w_trial;
    logic [DIM_W:0]     w_diff;
    logic               w_ge;

    assign w_trial = {r_rem, r_quo[SLEEP_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_count = r_count;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_den   = r_den;
        if (i_start) begin
            n_busy  = 1'b1;
            n_count = CNT_W'(SLEEP_W - 1);
            n_quo   = i_dividend;
            n_rem   = '0;
            n_den   = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[SLEEP_W-2:0], w_ge};
            n_rem = w_ge ? w_diff[DIM_W-1:0] : w_trial[DIM_W-1:0];
            if (r_count == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_count = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_count <= n_count;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

[hdl/lpmc_checker.sv]
// Port-level checks of the lamp power-mode controller, bound to the top level.
// Depends on lpmc_pkg and lamp_power_mode_controller_top_macros.svh.
`include "lamp_power_mode_controller_top_macros.svh"

module lpmc_checker
    import lpmc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             o_in_ready,
    input  logic             o_out_valid,
    input  logic             i_out_ready,
    input  t_result          o_out
);

    logic w_in_beat;
    logic w_out_stall;

    assign w_in_beat   = i_in_valid && o_in_ready;
    assign w_out_stall = o_out_valid && !i_out_ready;

    `LPMC_ASSERT_NEXT(a_stall_holds, w_out_stall, o_out_valid && $stable(o_out))
    `LPMC_ASSERT_NEXT(a_beat_gives_result, w_in_beat, o_out_valid)
    `LPMC_ASSERT_NOW(a_no_take_while_full, w_out_stall, !o_in_ready)
    `LPMC_ASSERT_NOW(a_quiet_beacon, o_out_valid && !o_out.beacon_fire,
        o_out.beacon_kind == 2'd0 && !o_out.beacon_broadcast && o_out.beacon_dest == 8'd0)
    `LPMC_ASSERT_NOW(a_bcast_is_request, o_out_valid && o_out.beacon_broadcast,
        o_out.beacon_fire && o_out.beacon_kind == 2'd0)

endmodule

bind lamp_power_mode_controller_top lpmc_checker u_lpmc_checker (.*);
